// ----- rtl/core/mbl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_pkg
// Shared types and constants of the multivoice breakpoint lfo unit.
// ----------------------------------------------------------------------------
package mbl_pkg;

    localparam int VOICES_DEF = 16;
    localparam int NUM_POINTS = 8;
    localparam int MAX_POINTS = 8;
    localparam int PIW        = $clog2(NUM_POINTS);

    // divider operand widths: |num| < 2^32, |dx| <= 2^16
    localparam int NUM_W = 32;
    localparam int DEN_W = 17;

    typedef struct packed {
        logic        [15:0] x;
        logic signed [15:0] y;
    } t_point;

    typedef struct packed {
        logic signed [15:0]             edge_height;
        logic        [3:0]              point_count;
        t_point      [NUM_POINTS-1:0]   points;
    } t_shape_cfg;

endpackage

// ----- rtl/core/mbl_voice_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_voice_mem
// Per-voice phase and last-time store, one read and one write port, read
// data registered. Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module mbl_voice_mem #(
    parameter int VOICES = mbl_pkg::VOICES_DEF,
    parameter int AW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_phase,
    output logic [31:0]   o_rd_time,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_phase,
    input  logic [31:0]   i_wr_time
);
    import mbl_pkg::*;

    logic [63:0]       r_mem [VOICES];
    logic [VOICES-1:0] r_valid;
    logic [63:0]       r_rd_data;
    logic              r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_phase, i_wr_time};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_phase = r_rd_hit ? r_rd_data[63:32] : 32'd0;
    assign o_rd_time  = r_rd_hit ? r_rd_data[31:0]  : 32'd0;

endmodule

// ----- rtl/core/mbl_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module mbl_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mbl_pkg::NUM_W-1:0] i_dividend,
    input  logic [mbl_pkg::DEN_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [mbl_pkg::NUM_W-1:0] o_quot
);
    import mbl_pkg::*;

    localparam int STEPS = NUM_W / 2;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_count;
    logic [NUM_W-1:0] r_acc;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] n_acc;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        logic [DEN_W:0] t;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            t     = {n_rem, n_acc[NUM_W-1]};
            n_acc = {n_acc[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t        = t - {1'b0, r_den};
                n_acc[0] = 1'b1;
            end
            n_rem = t[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CW'(STEPS - 1);
                r_acc   <= i_dividend;
                r_rem   <= '0;
                r_den   <= i_divisor;
            end else if (r_busy) begin
                r_acc   <= n_acc;
                r_rem   <= n_rem;
                r_count <= r_count - CW'(1);
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

// ----- rtl/core/mbl_shape_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_shape_eval
// Breakpoint segment scan, one point per cycle, then interpolation through
// a registered multiply and the serial divider, with saturation.
// ----------------------------------------------------------------------------
module mbl_shape_eval (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [15:0]             i_cur,
    input  mbl_pkg::t_shape_cfg     i_cfg,
    output logic                    o_done,
    output logic signed [15:0]      o_value
);
    import mbl_pkg::*;

    localparam logic [16:0] RX_ONE = 17'h10000;

    typedef enum logic [2:0] {
        SH_IDLE,
        SH_SCAN,
        SH_PREP,
        SH_SIGN,
        SH_DIV,
        SH_DONE
    } t_sh_state;

    t_sh_state          r_state;
    logic [15:0]        r_cur;
    logic [15:0]        r_lx;
    logic signed [15:0] r_ly;
    logic [16:0]        r_rx;
    logic signed [15:0] r_ry;
    logic [3:0]         r_idx;
    logic [3:0]         r_n;
    logic signed [33:0] r_num;
    logic signed [17:0] r_dx;
    logic               r_neg;
    logic signed [15:0] r_result;

    logic [3:0]         w_n;
    t_point             w_pt;
    logic               w_hit;
    logic               w_beyond;
    logic [16:0]        w_rx_e;
    logic signed [15:0] w_ry_e;
    logic signed [17:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [16:0] w_dc;
    logic [33:0]        w_num_abs;
    logic [17:0]        w_dx_abs;
    logic               w_div_start;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quot;
    logic [33:0]        w_q;
    logic [33:0]        w_y;

    assign w_n   = (i_cfg.point_count > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : i_cfg.point_count;
    assign w_pt  = i_cfg.points[r_idx[PIW-1:0]];
    assign w_hit = (r_cur >= r_lx) && (r_cur <= w_pt.x);

    assign w_beyond = {1'b0, r_cur} > r_rx;
    assign w_rx_e   = w_beyond ? RX_ONE : r_rx;
    assign w_ry_e   = w_beyond ? i_cfg.edge_height : r_ry;
    assign w_dx     = $signed({1'b0, w_rx_e}) - $signed({2'b00, r_lx});
    assign w_dy     = $signed({w_ry_e[15], w_ry_e}) - $signed({r_ly[15], r_ly});
    assign w_dc     = $signed({1'b0, r_cur}) - $signed({1'b0, r_lx});

    assign w_num_abs = r_num[33] ? (~r_num + 34'd1) : r_num;
    assign w_dx_abs  = r_dx[17] ? (~r_dx + 18'd1) : r_dx;

    assign w_div_start = (r_state == SH_SIGN);
    assign w_q = r_neg ? (~{2'b00, w_quot} + 34'd1) : {2'b00, w_quot};
    assign w_y = {{18{r_ly[15]}}, r_ly} + w_q;

    mbl_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_num_abs[NUM_W-1:0]),
        .i_divisor  (w_dx_abs[DEN_W-1:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SH_IDLE;
        end else begin
            unique case (r_state)
                SH_IDLE: begin
                    if (i_start) begin
                        r_cur   <= i_cur;
                        r_lx    <= '0;
                        r_ly    <= i_cfg.edge_height;
                        r_rx    <= RX_ONE;
                        r_ry    <= i_cfg.edge_height;
                        r_idx   <= '0;
                        r_n     <= w_n;
                        r_state <= SH_SCAN;
                    end
                end
                SH_SCAN: begin
                    if (r_idx == r_n) begin
                        r_state <= SH_PREP;
                    end else begin
                        r_rx <= {1'b0, w_pt.x};
                        if (w_hit) begin
                            r_ry    <= w_pt.y;
                            r_state <= SH_PREP;
                        end else begin
                            r_lx  <= w_pt.x;
                            r_ly  <= w_pt.y;
                            r_idx <= r_idx + 4'd1;
                        end
                    end
                end
                SH_PREP: begin
                    if (w_dx == '0) begin
                        r_result <= w_ry_e;
                        r_state  <= SH_DONE;
                    end else begin
                        r_num   <= w_dy * w_dc;
                        r_dx    <= w_dx;
                        r_state <= SH_SIGN;
                    end
                end
                SH_SIGN: begin
                    r_neg   <= r_num[33] ^ r_dx[17];
                    r_state <= SH_DIV;
                end
                SH_DIV: begin
                    if (w_div_done) begin
                        if ($signed(w_y) > 34'sd32767) begin
                            r_result <= 16'sh7FFF;
                        end else if ($signed(w_y) < -34'sd32768) begin
                            r_result <= 16'sh8000;
                        end else begin
                            r_result <= $signed(w_y[15:0]);
                        end
                        r_state <= SH_DONE;
                    end
                end
                SH_DONE: begin
                    r_state <= SH_IDLE;
                end
                default: begin
                    r_state <= SH_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_state == SH_DONE);
    assign o_value = r_result;

endmodule

// ----- rtl/core/multivoice_breakpoint_lfo_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multivoice_breakpoint_lfo_unit
// Per-voice phase accumulator with a piecewise-linear breakpoint shape.
//
//   channel  direction  handshake              beat
//   in       input      i_in_valid/o_in_stall  i_voice, i_now_ticks
//   out      output     o_out_valid/i_out_stall o_lfo_value, o_phase_now
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item at a time: read, multiply, write back, then the shape unit
// enabled shape: the one-point-per-cycle scan, then the multiply and the divider;
// a zero-width segment skips the divider
// disabled shape or bad voice: the shape unit is skipped and the value is zero
// reset clears the per-voice store at once through valid bits, no sweep
// a result waits in the output register; the next item is taken meanwhile
// and only its final load waits on a stalled output
// ----------------------------------------------------------------------------
module multivoice_breakpoint_lfo_unit #(
    parameter int VOICES = mbl_pkg::VOICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_voice,
    input  logic [31:0]        i_now_ticks,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_lfo_value,
    output logic [15:0]        o_phase_now,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import mbl_pkg::*;

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [2:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_EDGE_HEIGHT  = 3'd1,
        REG_POINT_COUNT  = 3'd2,
        REG_PAIR_A       = 3'd3,
        REG_PAIR_B       = 3'd4,
        REG_PAIR_C       = 3'd5,
        REG_PAIR_D       = 3'd6,
        REG_SHAPE_ENABLE = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SHAPE,
        S_LOAD
    } t_state;

    logic [31:0]        r_phase_step;
    logic signed [15:0] r_edge_height;
    logic [3:0]         r_point_count;
    logic [63:0]        r_pair [4];
    logic               r_shape_enable;

    t_state             r_state;
    logic [AW-1:0]      r_addr;
    logic               r_in_range;
    logic [31:0]        r_now;
    logic               r_back;
    logic [31:0]        r_adv;
    logic [31:0]        r_old_phase;
    logic [15:0]        r_phase_now;
    logic signed [15:0] r_value;
    logic               r_out_valid;
    logic signed [15:0] r_out_value;
    logic [15:0]        r_out_phase;

    logic               w_accept;
    logic               w_range;
    logic [31:0]        w_rd_phase;
    logic [31:0]        w_rd_time;
    logic [31:0]        w_elapsed;
    logic [31:0]        w_adv;
    logic [31:0]        w_new_phase;
    logic               w_wr_en;
    logic               w_shape_start;
    logic               w_shape_done;
    logic signed [15:0] w_shape_value;
    logic               w_load;
    t_shape_cfg         w_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_edge_height  <= '0;
            r_point_count  <= '0;
            r_pair[0]      <= '0;
            r_pair[1]      <= '0;
            r_pair[2]      <= '0;
            r_pair[3]      <= '0;
            r_shape_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_data[31:0];
                REG_EDGE_HEIGHT:  r_edge_height  <= $signed(i_cfg_data[15:0]);
                REG_POINT_COUNT:  r_point_count  <= i_cfg_data[3:0];
                REG_PAIR_A:       r_pair[0]      <= i_cfg_data;
                REG_PAIR_B:       r_pair[1]      <= i_cfg_data;
                REG_PAIR_C:       r_pair[2]      <= i_cfg_data;
                REG_PAIR_D:       r_pair[3]      <= i_cfg_data;
                REG_SHAPE_ENABLE: r_shape_enable <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg.edge_height = r_edge_height;
        w_cfg.point_count = r_point_count;
        for (int k = 0; k < NUM_POINTS / 2; k++) begin
            w_cfg.points[2*k].x   = r_pair[k][15:0];
            w_cfg.points[2*k].y   = $signed(r_pair[k][31:16]);
            w_cfg.points[2*k+1].x = r_pair[k][47:32];
            w_cfg.points[2*k+1].y = $signed(r_pair[k][63:48]);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_range    = 32'(i_voice) < 32'(VOICES);

    assign w_elapsed   = r_now - w_rd_time;
    assign w_adv       = w_elapsed * r_phase_step;
    assign w_new_phase = r_back ? 32'd0 : (r_old_phase + r_adv);
    assign w_wr_en     = (r_state == S_UPDATE) && r_in_range;
    assign w_shape_start = (r_state == S_UPDATE) && r_in_range && r_shape_enable;
    assign w_load      = (r_state == S_LOAD) && (!r_out_valid || !i_out_stall);

    mbl_voice_mem #(
        .VOICES (VOICES),
        .AW     (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept && w_range),
        .i_rd_addr  (AW'(i_voice)),
        .o_rd_phase (w_rd_phase),
        .o_rd_time  (w_rd_time),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_addr),
        .i_wr_phase (w_new_phase),
        .i_wr_time  (r_now)
    );

    mbl_shape_eval u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_shape_start),
        .i_cur   (w_new_phase[31:16]),
        .i_cfg   (w_cfg),
        .o_done  (w_shape_done),
        .o_value (w_shape_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_addr     <= AW'(i_voice);
                        r_in_range <= w_range;
                        r_now      <= i_now_ticks;
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_back      <= r_now < w_rd_time;
                    r_adv       <= w_adv;
                    r_old_phase <= w_rd_phase;
                    r_state     <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_phase_now <= r_in_range ? w_new_phase[31:16] : 16'd0;
                    if (w_shape_start) begin
                        r_state <= S_SHAPE;
                    end else begin
                        r_value <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_SHAPE: begin
                    if (w_shape_done) begin
                        r_value <= w_shape_value;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (w_load) begin
                        r_out_value <= r_value;
                        r_out_phase <= r_phase_now;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lfo_value = r_out_value;
    assign o_phase_now = r_out_phase;

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_READ))
        else $error("accepted beat did not start a read");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_UPDATE) && r_in_range && $past(r_state == S_READ))
        else $error("voice store written outside the update step");

    a_shape_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shape_done |-> (r_state == S_SHAPE))
        else $error("shape result arrived with no item waiting");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid && (o_phase_now == $past(r_phase_now)))
        else $error("loaded result not presented");

    a_bad_voice_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPDATE) && !r_in_range) |=> (r_phase_now == 16'd0) && (r_value == '0))
        else $error("out of range voice gave a nonzero result");
`endif

endmodule

// ----- bench/tb_multivoice_breakpoint_lfo_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multivoice_breakpoint_lfo_unit
// Self-checking bench for the multivoice breakpoint lfo unit. A scoreboard
// class keeps its own per-voice phase and time and its own copy of the shape
// registers, predicts lfo_value and phase_now for every input beat and checks
// each output beat in order. Plain tasks drive input bursts and register
// writes over a directed part and six random register settings, while a
// random output stall pattern runs alongside.
// ----------------------------------------------------------------------------
module tb_multivoice_breakpoint_lfo_unit;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 48;
    localparam int PHASE_ITEMS = 66;

    typedef enum logic [2:0] {
        REG_PHASE_STEP,
        REG_EDGE_HEIGHT,
        REG_POINT_COUNT,
        REG_PAIR_A,
        REG_PAIR_B,
        REG_PAIR_C,
        REG_PAIR_D,
        REG_SHAPE_ENABLE
    } reg_idx_e;

    typedef struct packed {
        logic signed [15:0] lfo;
        logic        [15:0] phase;
    } lfo_beat_t;

    class lfo_tracker;
        logic [31:0]         step;
        mbl_pkg::t_shape_cfg shape;
        logic                enable;
        logic [31:0]         phase_mem [16];
        logic [31:0]         last_tick [16];
        lfo_beat_t           awaited [$];
        int                  mismatches;
        int                  checked;

        function new();
            step       = '0;
            shape      = '0;
            enable     = 1'b0;
            mismatches = 0;
            checked    = 0;
            foreach (phase_mem[v]) begin
                phase_mem[v] = '0;
                last_tick[v] = '0;
            end
        endfunction

        function void write_reg(reg_idx_e idx, logic [63:0] data);
            int k;
            k = 2 * (int'(idx) - int'(REG_PAIR_A));
            case (idx)
                REG_PHASE_STEP:   step = data[31:0];
                REG_EDGE_HEIGHT:  shape.edge_height = data[15:0];
                REG_POINT_COUNT:  shape.point_count = data[3:0];
                REG_PAIR_A, REG_PAIR_B, REG_PAIR_C, REG_PAIR_D: begin
                    shape.points[k].x     = data[15:0];
                    shape.points[k].y     = data[31:16];
                    shape.points[k + 1].x = data[47:32];
                    shape.points[k + 1].y = data[63:48];
                end
                REG_SHAPE_ENABLE: enable = data[0];
                default: ;
            endcase
        endfunction

        // piecewise-linear lookup of the 16-bit phase position
        function int shape_at(int cur);
            int     lx, ly, rx, ry, n, dx, i;
            bit     hit;
            longint q, y;
            lx  = 0;
            ly  = $signed(shape.edge_height);
            rx  = 65536;
            ry  = ly;
            hit = 1'b0;
            n   = (shape.point_count > 4'd8) ? 8 : int'(shape.point_count);
            for (i = 0; i < n && !hit; i++) begin
                rx = int'(shape.points[i].x);
                if (cur >= lx && cur <= rx) begin
                    ry  = $signed(shape.points[i].y);
                    hit = 1'b1;
                end else begin
                    lx = rx;
                    ly = $signed(shape.points[i].y);
                end
            end
            if (cur > rx) begin
                rx = 65536;
                ry = $signed(shape.edge_height);
            end
            dx = rx - lx;
            if (dx == 0)
                return ry;
            q = (longint'(ry - ly) * longint'(cur - lx)) / longint'(dx);
            y = longint'(ly) + q;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            return int'(y);
        endfunction

        function void note_beat(logic [3:0] voice, logic [31:0] now);
            logic [31:0] ph, el;
            logic [63:0] adv;
            lfo_beat_t   b;
            ph = phase_mem[voice];
            if (now < last_tick[voice]) begin
                ph = '0;
            end else begin
                el  = now - last_tick[voice];
                adv = {32'd0, el} * {32'd0, step};
                ph  = ph + adv[31:0];
            end
            phase_mem[voice] = ph;
            last_tick[voice] = now;
            b.phase = ph[31:16];
            b.lfo   = enable ? 16'(shape_at(int'(ph[31:16]))) : 16'sd0;
            awaited.push_back(b);
        endfunction

        function void check_beat(logic signed [15:0] lfo, logic [15:0] ph);
            lfo_beat_t b;
            if (awaited.size() == 0) begin
                $error("output beat with nothing outstanding: lfo_value %0d phase_now %0h",
                       lfo, ph);
                mismatches++;
                return;
            end
            b = awaited.pop_front();
            checked++;
            if (lfo !== b.lfo) begin
                $error("lfo_value expected %0d actual %0d", b.lfo, lfo);
                mismatches++;
            end
            if (ph !== b.phase) begin
                $error("phase_now expected %0h actual %0h", b.phase, ph);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [3:0]         i_voice;
    logic [31:0]        i_now_ticks;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_lfo_value;
    logic [15:0]        o_phase_now;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;

    lfo_tracker  sb = new();
    logic [31:0] voice_clock [16];
    logic [63:0] pair_word [4];
    int          burst_left;
    int          items_sent;
    int          settings_used;
    int          quiet_cycles;

    multivoice_breakpoint_lfo_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_voice     (i_voice),
        .i_now_ticks (i_now_ticks),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_lfo_value (o_lfo_value),
        .o_phase_now (o_phase_now),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output stall pattern: free stretches, light and heavy stalling
    initial begin
        int mode, stretch;
        i_out_stall = 1'b0;
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(20, 200);
            repeat (stretch) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    default: i_out_stall <= ($urandom_range(0, 99) < 80);
                endcase
            end
        end
    end

    // output checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_lfo_value, o_phase_now);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d beats outstanding",
                     quiet_cycles, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_e idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic [31:0] step, input logic [15:0] height,
                                 input logic [3:0] count, input logic en);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_PHASE_STEP, {junk[63:32], step});
        write_reg(REG_EDGE_HEIGHT, {junk[63:16], height});
        write_reg(REG_POINT_COUNT, {junk[63:4], count});
        write_reg(REG_PAIR_A, pair_word[0]);
        write_reg(REG_PAIR_B, pair_word[1]);
        write_reg(REG_PAIR_C, pair_word[2]);
        write_reg(REG_PAIR_D, pair_word[3]);
        write_reg(REG_SHAPE_ENABLE, {junk[63:1], en});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic roll_points(input bit sorted);
        logic [15:0] x [8];
        logic [15:0] y [8];
        int          acc, i;
        acc = 0;
        for (i = 0; i < 8; i++) begin
            if (sorted) begin
                // repeated x now and then gives zero-width segments
                if ($urandom_range(0, 3) != 0)
                    acc += $urandom_range(1, 12000);
                if (acc > 65535)
                    acc = 65535;
                x[i] = 16'(acc);
            end else begin
                x[i] = 16'($urandom);
            end
            y[i] = 16'($urandom);
        end
        for (i = 0; i < 4; i++)
            pair_word[i] = {y[2*i+1], x[2*i+1], y[2*i], x[2*i]};
    endtask

    function automatic logic [31:0] next_tick(input logic [3:0] v);
        int unsigned r;
        logic [31:0] last;
        r    = $urandom_range(0, 99);
        last = voice_clock[v];
        if (r < 60)
            return last + $urandom_range(0, 40);
        if (r < 70)
            return last;
        if (r < 80)
            return (last == 0) ? 32'd0 : 32'($urandom_range(0, last - 1));
        if (r < 90)
            return $urandom;
        return last + $urandom_range(0, 32'h00FF_FFFF);
    endfunction

    task automatic run_item(input logic [3:0] v, input logic [31:0] t);
        int gap;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_voice     <= v;
        i_now_ticks <= t;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_beat(v, t);
        voice_clock[v] = t;
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(0, 24);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          p, i;
        logic [3:0]  v;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_voice       = '0;
        i_now_ticks   = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        burst_left    = 0;
        items_sent    = 0;
        settings_used = 0;
        quiet_cycles  = 0;
        foreach (voice_clock[k])
            voice_clock[k] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: (0,+max) (4000,-max) (8000,1234) (8000,-100), edges at -max
        pair_word[0] = {16'h8000, 16'h4000, 16'h7FFF, 16'h0000};
        pair_word[1] = {16'hFF9C, 16'h8000, 16'h1234, 16'h8000};
        pair_word[2] = {16'h7FFF, 16'hFFFF, 16'h8000, 16'hC000};
        pair_word[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        apply_setting(32'h0010_0000, 16'h8000, 4'd4, 1'b1);
        run_item(4'd0, 32'h0000_0000);
        run_item(4'd0, 32'h0000_1000);
        run_item(4'd0, 32'h0000_1400);
        run_item(4'd0, 32'h0000_1600);
        run_item(4'd0, 32'h0000_1800);
        run_item(4'd0, 32'h0000_1C00);
        run_item(4'd0, 32'h0000_1FFF);
        run_item(4'd0, 32'h0000_1000);
        run_item(4'd0, 32'h0000_1000);
        run_item(4'd15, 32'hFFFF_FFFF);
        run_item(4'd15, 32'h0000_0000);
        run_item(4'd15, 32'hFFFF_FFFF);
        run_item(4'd15, 32'hFFFF_FFFF);
        for (i = 1; i <= 12; i++)
            run_item(4'(i), 32'(i) * 32'h0000_0A3D);

        for (p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: begin
                    roll_points(1'b1);
                    apply_setting(32'h0, 16'h7FFF, 4'd0, 1'b1);
                end
                1: begin
                    roll_points(1'b1);
                    apply_setting(32'hFFFF_FFFF, 16'($urandom), 4'd15, 1'b1);
                end
                2: begin
                    roll_points(1'b0);
                    apply_setting($urandom, 16'($urandom), 4'($urandom_range(1, 8)), 1'b1);
                end
                3: begin
                    roll_points(1'b1);
                    apply_setting($urandom, 16'($urandom), 4'd8, 1'b0);
                end
                4: begin
                    roll_points(1'b1);
                    apply_setting($urandom_range(0, 32'h00FF_FFFF), 16'($urandom),
                                  4'($urandom_range(1, 8)), 1'b1);
                end
                default: begin
                    roll_points(1'($urandom_range(0, 1)));
                    apply_setting($urandom, 16'($urandom), 4'($urandom), 1'b1);
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                v = 4'($urandom_range(0, 15));
                run_item(v, next_tick(v));
            end
        end
        settle();

        $display("run covered %0d input beats over %0d register settings",
                 items_sent, settings_used);
        $display("%0d output beats checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
